/* hw/rtl/slsa_pkg.sv */
package slsa_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [15:0] mat_t;
    typedef word_t [3:0]  lane_vec_t;

    // "expand 32-byte k"
    localparam word_t SIGMA0 = 32'h6170_7865;
    localparam word_t SIGMA1 = 32'h3320_646e;
    localparam word_t SIGMA2 = 32'h7962_2d32;
    localparam word_t SIGMA3 = 32'h6b20_6574;

    localparam int unsigned ROT0 = 7;
    localparam int unsigned ROT1 = 9;
    localparam int unsigned ROT2 = 13;
    localparam int unsigned ROT3 = 18;

    localparam int unsigned NUM_REGS = 5;
    localparam logic [2:0] REG_KEY0  = 3'd0;
    localparam logic [2:0] REG_KEY1  = 3'd1;
    localparam logic [2:0] REG_KEY2  = 3'd2;
    localparam logic [2:0] REG_KEY3  = 3'd3;
    localparam logic [2:0] REG_NONCE = 3'd4;

    // Lane form: slot = lane*4 + pos, lane tuple is (a, b, c, d) of a quarter-round.
    // Matrix word held at each slot in column-round form.
    localparam logic [3:0] COL_X [16] = '{
        4'd0,  4'd4,  4'd8,  4'd12,
        4'd5,  4'd9,  4'd13, 4'd1,
        4'd10, 4'd14, 4'd2,  4'd6,
        4'd15, 4'd3,  4'd7,  4'd11
    };
    // Matrix word held at each slot in row-round form.
    localparam logic [3:0] ROW_X [16] = '{
        4'd0,  4'd1,  4'd2,  4'd3,
        4'd5,  4'd6,  4'd7,  4'd4,
        4'd10, 4'd11, 4'd8,  4'd9,
        4'd15, 4'd12, 4'd13, 4'd14
    };
    // Slot of each matrix word in column form.
    localparam logic [3:0] COL_POS [16] = '{
        4'd0,  4'd7,  4'd10, 4'd13,
        4'd1,  4'd4,  4'd11, 4'd14,
        4'd2,  4'd5,  4'd8,  4'd15,
        4'd3,  4'd6,  4'd9,  4'd12
    };
    // Slot of each matrix word in row form.
    localparam logic [3:0] ROW_POS [16] = '{
        4'd0,  4'd1,  4'd2,  4'd3,
        4'd7,  4'd4,  4'd5,  4'd6,
        4'd10, 4'd11, 4'd8,  4'd9,
        4'd13, 4'd14, 4'd15, 4'd12
    };

    typedef struct packed {
        logic       ff;     // feed-forward add only
        logic [1:0] step;   // quarter-round step, picks rotate amount
    } lane_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    function automatic word_t rotl(word_t v, int unsigned d);
        return (v << d) | (v >> (32 - d));
    endfunction

endpackage

/* hw/rtl/slsa_lane_unit.sv */
module slsa_lane_unit (
    input  slsa_pkg::lane_ctl_t ctl,
    input  slsa_pkg::lane_vec_t op_a,
    input  slsa_pkg::lane_vec_t op_b,
    input  slsa_pkg::lane_vec_t op_x,
    output slsa_pkg::lane_vec_t res
);
    import slsa_pkg::*;

    lane_vec_t sum;
    lane_vec_t rot;

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            sum[l] = op_a[l] + op_b[l];
            case (ctl.step)
                2'd0:    rot[l] = rotl(sum[l], ROT0);
                2'd1:    rot[l] = rotl(sum[l], ROT1);
                2'd2:    rot[l] = rotl(sum[l], ROT2);
                default: rot[l] = rotl(sum[l], ROT3);
            endcase
            res[l] = ctl.ff ? sum[l] : (op_x[l] ^ rot[l]);
        end
    end

endmodule

/* hw/rtl/slsa_core.sv */
module slsa_core #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  slsa_pkg::mat_t       in_mat,
    input  logic [3:0]           rd_idx,
    output slsa_pkg::word_t      rd_word,
    output slsa_pkg::core_stat_t stat
);
    import slsa_pkg::*;

    localparam int HALF_ROUNDS = 2 * DOUBLE_ROUNDS;
    localparam int HW = $clog2(HALF_ROUNDS);
    localparam logic [HW-1:0] LAST_HALF = HW'(HALF_ROUNDS - 1);

    typedef enum logic [2:0] {
        C_IDLE  = 3'b001,
        C_ROUND = 3'b010,
        C_FF    = 3'b100
    } cstate_t;

    cstate_t        state_reg, state_next;
    logic [1:0]     step_reg, step_next;
    logic [HW-1:0]  half_reg, half_next;
    logic           done_reg, done_next;
    mat_t           w_reg, w_next;
    mat_t           ks_reg;
    mat_t           rot_t;

    lane_ctl_t      ctl;
    lane_vec_t      op_a, op_b, op_x, res;

    assign ctl.ff   = (state_reg == C_FF);
    assign ctl.step = step_reg;

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            op_a[l] = w_reg[4*l];
            op_x[l] = w_reg[4*l + 1];
            op_b[l] = ctl.ff ? in_mat[COL_X[{2'(l), step_reg}]] : w_reg[4*l + 3];
        end
    end

    slsa_lane_unit u_lane (
        .ctl  (ctl),
        .op_a (op_a),
        .op_b (op_b),
        .op_x (op_x),
        .res  (res)
    );

    // each lane tuple shifts by one so the unit always reads fixed slots
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            rot_t[4*l]     = ctl.ff ? w_reg[4*l + 1] : res[l];
            rot_t[4*l + 1] = w_reg[4*l + 2];
            rot_t[4*l + 2] = w_reg[4*l + 3];
            rot_t[4*l + 3] = w_reg[4*l];
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        half_next  = half_reg;
        done_next  = 1'b0;
        w_next     = w_reg;
        case (state_reg)
            C_IDLE: begin
                if (start) begin
                    for (int f = 0; f < 16; f++) w_next[f] = in_mat[COL_X[f]];
                    step_next  = 2'd0;
                    half_next  = '0;
                    state_next = C_ROUND;
                end
            end
            C_ROUND: begin
                step_next = step_reg + 2'd1;
                w_next    = rot_t;
                if (step_reg == 2'd3) begin
                    // regroup lanes for the other round direction
                    for (int f = 0; f < 16; f++) begin
                        if (!half_reg[0]) w_next[f] = rot_t[COL_POS[ROW_X[f]]];
                        else              w_next[f] = rot_t[ROW_POS[COL_X[f]]];
                    end
                    if (half_reg == LAST_HALF) state_next = C_FF;
                    else                       half_next  = half_reg + HW'(1);
                end
            end
            C_FF: begin
                step_next = step_reg + 2'd1;
                w_next    = rot_t;
                if (step_reg == 2'd3) begin
                    state_next = C_IDLE;
                    done_next  = 1'b1;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            step_reg  <= 2'd0;
            half_reg  <= '0;
            done_reg  <= 1'b0;
            ks_reg    <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            half_reg  <= half_next;
            done_reg  <= done_next;
            if (state_reg == C_FF) begin
                for (int x = 0; x < 16; x++) begin
                    if (COL_POS[x][1:0] == step_reg) ks_reg[x] <= res[COL_POS[x][3:2]];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        w_reg <= w_next;
    end

    assign rd_word   = ks_reg[rd_idx];
    assign stat.busy = (state_reg != C_IDLE);
    assign stat.done = done_reg;

endmodule

/* hw/rtl/salsa20_stream_cipher_top.sv */
// Salsa20 stream cipher, one byte per word.
// Input channel s_*: tdata carries the byte to encrypt or decrypt, tuser marks
// the first byte of a message (block counter and byte position restart at 0).
// Output channel m_*: tdata is the input byte XOR the next keystream byte,
// one output word per input word, in order.
// Config channel cfg_*: always ready; index 0..3 write key words (pairs),
// index 4 the nonce, higher indexes are dropped. Write only while idle.
// When the keystream block is already on hand, an accepted byte goes through
// ST_EMIT into the output register. A new block is first generated in the
// core (ST_LOAD, ST_GEN): the 4-lane add/rotate/xor unit runs one
// quarter-round step per cycle, then the feed-forward adds of the input matrix.
// A byte is accepted only while idle, so the next byte waits until the current
// one is emitted; a fresh block is needed every 64 bytes.
// Reset clears key, nonce, counter and position; the first byte after reset
// uses block 0. The output word sits in a register; while m_tready is low the
// next input word is still accepted and its keystream block generated, but it
// is not emitted until the held word is taken.
module salsa20_stream_cipher_top #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_in
    input  logic        s_tuser,   // [0] message_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] data_out
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import slsa_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_GEN  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg, nonce_reg;
    logic [63:0] cnt_reg, cnt_next;
    logic [5:0]  pos_reg, pos_next;
    logic        blk_ok_reg, blk_ok_next;
    logic [7:0]  data_reg, data_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [7:0]  m_tdata_reg, m_tdata_next;

    mat_t        in_mat;
    word_t       ks_word;
    logic [31:0] ks_shift;
    core_stat_t  cstat;
    logic        core_start;
    logic        s_fire, emit_fire;

    assign in_mat[0]  = SIGMA0;
    assign in_mat[1]  = key0_reg[31:0];
    assign in_mat[2]  = key0_reg[63:32];
    assign in_mat[3]  = key1_reg[31:0];
    assign in_mat[4]  = key1_reg[63:32];
    assign in_mat[5]  = SIGMA1;
    assign in_mat[6]  = nonce_reg[31:0];
    assign in_mat[7]  = nonce_reg[63:32];
    assign in_mat[8]  = cnt_reg[31:0];
    assign in_mat[9]  = cnt_reg[63:32];
    assign in_mat[10] = SIGMA2;
    assign in_mat[11] = key2_reg[31:0];
    assign in_mat[12] = key2_reg[63:32];
    assign in_mat[13] = key3_reg[31:0];
    assign in_mat[14] = key3_reg[63:32];
    assign in_mat[15] = SIGMA3;

    assign core_start = (state_reg == ST_LOAD);

    slsa_core #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (core_start),
        .in_mat  (in_mat),
        .rd_idx  (pos_reg[5:2]),
        .rd_word (ks_word),
        .stat    (cstat)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign emit_fire = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);
    assign ks_shift  = ks_word >> {pos_reg[1:0], 3'b000};

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        pos_next      = pos_reg;
        blk_ok_next   = blk_ok_reg;
        data_next     = data_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    data_next = s_tdata;
                    if (s_tuser) begin
                        cnt_next    = '0;
                        pos_next    = '0;
                        blk_ok_next = 1'b0;
                    end
                    state_next = (s_tuser || !blk_ok_reg) ? ST_LOAD : ST_EMIT;
                end
            end
            ST_LOAD: state_next = ST_GEN;
            ST_GEN: begin
                if (cstat.done) begin
                    blk_ok_next = 1'b1;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_fire) begin
                    m_tdata_next  = data_reg ^ ks_shift[7:0];
                    m_tvalid_next = 1'b1;
                    pos_next      = pos_reg + 6'd1;
                    if (pos_reg == 6'd63) begin
                        // block used up, next byte needs a fresh one
                        cnt_next    = cnt_reg + 64'd1;
                        blk_ok_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            pos_reg      <= '0;
            blk_ok_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            key0_reg     <= '0;
            key1_reg     <= '0;
            key2_reg     <= '0;
            key3_reg     <= '0;
            nonce_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            pos_reg      <= pos_next;
            blk_ok_reg   <= blk_ok_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_KEY0:  key0_reg  <= cfg_data;
                    REG_KEY1:  key1_reg  <= cfg_data;
                    REG_KEY2:  key2_reg  <= cfg_data;
                    REG_KEY3:  key3_reg  <= cfg_data;
                    REG_NONCE: nonce_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg    <= data_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

endmodule
